/* hdl/cidr_pkg.sv */
// Shared types, codes and mask helpers for the CIDR allowlist filter.
package cidr_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam int V4_BITS = 32;
  localparam int V6_BITS = 128;
  localparam int V4_PFX_W = 6;
  localparam int V6_PFX_W = 8;

  localparam logic [7:0] V4_LOOPBACK_NET = 8'd127;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  typedef enum logic [2:0] {
    ST_LOOPBACK = 3'd0,
    ST_MATCHED  = 3'd1,
    ST_OTHER    = 3'd2,
    ST_BLOCKED  = 3'd3,
    ST_ADDED    = 3'd4,
    ST_FULL     = 3'd5,
    ST_IGNORED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [V4_BITS-1:0]  network;
    logic [V4_PFX_W-1:0] prefix;
  } v4_entry_t;

  typedef struct packed {
    logic [V6_BITS-1:0]  network;
    logic [V6_PFX_W-1:0] prefix;
  } v6_entry_t;

  // prefix is at most 32; a shift by the full width gives an all-ones mask
  function automatic logic [V4_BITS-1:0] mask_v4(input logic [V4_PFX_W-1:0] p);
    return ~({V4_BITS{1'b1}} >> p);
  endfunction

  // prefix is at most 128
  function automatic logic [V6_BITS-1:0] mask_v6(input logic [V6_PFX_W-1:0] p);
    return ~({V6_BITS{1'b1}} >> p);
  endfunction

endpackage

/* hdl/cidr_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
module cidr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/cidr_match.sv */
// Compares the checked address against one stored range of its family.
module cidr_match import cidr_pkg::*; (
  input  logic [1:0]         family,
  input  logic [63:0]        addr_hi,
  input  logic [63:0]        addr_lo,
  input  v4_entry_t          v4_entry,
  input  v6_entry_t          v6_entry,
  output logic               hit
);

  logic [V4_BITS-1:0] v4_addr;
  logic [V6_BITS-1:0] v6_addr;
  logic               v4_hit;
  logic               v6_hit;

  assign v4_addr = addr_lo[V4_BITS-1:0];
  assign v6_addr = {addr_hi, addr_lo};

  // stored networks are already masked, so only the address needs masking
  assign v4_hit = (v4_addr & mask_v4(v4_entry.prefix)) == v4_entry.network;
  assign v6_hit = (v6_addr & mask_v6(v6_entry.prefix)) == v6_entry.network;

  assign hit = (family == FAM_V4) ? v4_hit : v6_hit;

endmodule

/* hdl/cidr_allowlist_filter.sv */
// Top level of the CIDR allowlist filter: control sequencer, tables and output register.
//
// Each accepted word is either an add or a check. An add, a loopback check and a
// check of another family go through S_EXEC and S_OUT before the result sits in
// the output register; S_OUT holds while that register keeps an untaken result,
// and the next word is taken back in S_IDLE. A check against a table holding n
// ranges (up to 256) reads the table RAM one entry per cycle and stops at the
// first match or the last stored range; the single read port of the table sets
// that pace. Only one word is in work at a time, but a new word is taken while
// the previous result still waits in the output register.
module cidr_allowlist_filter import cidr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [1:0]  family,
  input  logic [63:0] addr_hi,
  input  logic [63:0] addr_lo,
  input  logic [7:0]  prefix_len,
  input  logic [15:0] port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        allowed,
  output logic        log_event,
  output logic [15:0] port_out
);

  state_t            state, state_next;
  logic              log_allowed;

  logic              item_cmd;
  logic [1:0]        item_family;
  logic [63:0]       item_hi;
  logic [63:0]       item_lo;
  logic [7:0]        item_prefix;
  logic [15:0]       item_port;

  logic [CNT_W-1:0]  v4_count, v4_count_next;
  logic [CNT_W-1:0]  v6_count, v6_count_next;
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;

  status_t           res_status, res_status_next;
  logic              res_allowed, res_allowed_next;
  logic              res_log, res_log_next;

  logic              v4_we, v6_we, rd_en;
  logic [IDX_W-1:0]  rd_addr;
  v4_entry_t         v4_wentry, v4_rentry;
  v6_entry_t         v6_wentry, v6_rentry;

  logic [V4_PFX_W-1:0] v4_plen;
  logic [V6_PFX_W-1:0] v6_plen;
  logic                is_loopback;
  logic [CNT_W-1:0]    count_sel;
  logic                scan_last;
  logic                hit;
  logic                out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // saturate the prefix length to the family width
  assign v4_plen = (item_prefix > 8'(V4_BITS)) ? V4_PFX_W'(V4_BITS) : item_prefix[V4_PFX_W-1:0];
  assign v6_plen = (item_prefix > 8'(V6_BITS)) ? V6_PFX_W'(V6_BITS) : item_prefix;

  assign v4_wentry.network = item_lo[V4_BITS-1:0] & mask_v4(v4_plen);
  assign v4_wentry.prefix  = v4_plen;
  assign v6_wentry.network = {item_hi, item_lo} & mask_v6(v6_plen);
  assign v6_wentry.prefix  = v6_plen;

  assign is_loopback = (item_family == FAM_V4) ? (item_lo[31:24] == V4_LOOPBACK_NET)
                                               : (item_hi == 64'd0 && item_lo == 64'd1);

  assign count_sel = (item_family == FAM_V4) ? v4_count : v6_count;
  assign scan_last = (CNT_W'(scan_idx) + CNT_W'(1)) == count_sel;

  cidr_ram #(
    .WIDTH($bits(v4_entry_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_v4_ram (
    .clk   (clk),
    .we    (v4_we),
    .waddr (v4_count[IDX_W-1:0]),
    .wdata (v4_wentry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (v4_rentry)
  );

  cidr_ram #(
    .WIDTH($bits(v6_entry_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_v6_ram (
    .clk   (clk),
    .we    (v6_we),
    .waddr (v6_count[IDX_W-1:0]),
    .wdata (v6_wentry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (v6_rentry)
  );

  cidr_match u_match (
    .family   (item_family),
    .addr_hi  (item_hi),
    .addr_lo  (item_lo),
    .v4_entry (v4_rentry),
    .v6_entry (v6_rentry),
    .hit      (hit)
  );

  always_comb begin
    state_next       = state;
    v4_count_next    = v4_count;
    v6_count_next    = v6_count;
    scan_idx_next    = scan_idx;
    res_status_next  = res_status;
    res_allowed_next = res_allowed;
    res_log_next     = res_log;
    v4_we            = 1'b0;
    v6_we            = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next       = S_OUT;
        res_allowed_next = 1'b0;
        res_log_next     = 1'b0;
        if (item_cmd == CMD_ADD) begin
          if (item_family != FAM_V4 && item_family != FAM_V6) begin
            res_status_next = ST_IGNORED;
          end else if (count_sel == CNT_W'(MAX_ENTRIES)) begin
            res_status_next = ST_FULL;
          end else begin
            res_status_next  = ST_ADDED;
            res_allowed_next = 1'b1;
            if (item_family == FAM_V4) begin
              v4_we         = 1'b1;
              v4_count_next = v4_count + CNT_W'(1);
            end else begin
              v6_we         = 1'b1;
              v6_count_next = v6_count + CNT_W'(1);
            end
          end
        end else begin
          if (item_family != FAM_V4 && item_family != FAM_V6) begin
            res_status_next  = ST_OTHER;
            res_allowed_next = 1'b1;
          end else if (is_loopback) begin
            res_status_next  = ST_LOOPBACK;
            res_allowed_next = 1'b1;
          end else if (count_sel == '0) begin
            res_status_next = ST_BLOCKED;
            res_log_next    = 1'b1;
          end else begin
            // fetch the first entry; the scan compares it next cycle
            rd_en         = 1'b1;
            rd_addr       = '0;
            scan_idx_next = '0;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        priority if (hit) begin
          res_status_next  = ST_MATCHED;
          res_allowed_next = 1'b1;
          res_log_next     = log_allowed;
          state_next       = S_OUT;
        end else if (scan_last) begin
          res_status_next = ST_BLOCKED;
          res_log_next    = 1'b1;
          state_next      = S_OUT;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = scan_idx + IDX_W'(1);
          scan_idx_next = scan_idx + IDX_W'(1);
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      log_allowed <= 1'b0;
      v4_count    <= '0;
      v6_count    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      v4_count <= v4_count_next;
      v6_count <= v6_count_next;
      if (cfg_we) begin
        log_allowed <= cfg_wdata;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx    <= scan_idx_next;
    res_status  <= res_status_next;
    res_allowed <= res_allowed_next;
    res_log     <= res_log_next;
    // capture the word on acceptance
    if (in_valid && in_ready) begin
      item_cmd    <= cmd;
      item_family <= family;
      item_hi     <= addr_hi;
      item_lo     <= addr_lo;
      item_prefix <= prefix_len;
      item_port   <= port;
    end
    if (state == S_OUT && out_free) begin
      status    <= res_status;
      allowed   <= res_allowed;
      log_event <= res_log;
      port_out  <= item_port;
    end
  end

endmodule
